@@ hw/rtl/mips_subset_instruction_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// MIPS subset decoder assertion macros
// Shared concurrent assertion forms, clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define MIPS_SUBSET_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// Same-cycle implication.
`define MSID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/msid_pkg.sv @@
// ----------------------------------------------------------------------------
// MIPS subset decoder package
// Opcode and funct encodings, result kind codes, the data start reset value.
// ----------------------------------------------------------------------------
package msid_pkg;

    localparam logic [31:0] DATA_START_RESET = 32'd700;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'b000000;
    localparam logic [5:0] OP_REGIMM  = 6'b000001;
    localparam logic [5:0] OP_J       = 6'b000010;
    localparam logic [5:0] OP_BEQ     = 6'b000100;
    localparam logic [5:0] OP_BNE     = 6'b000101;
    localparam logic [5:0] OP_BLEZ    = 6'b000110;
    localparam logic [5:0] OP_BGTZ    = 6'b000111;
    localparam logic [5:0] OP_ADDI    = 6'b001000;
    localparam logic [5:0] OP_ADDIU   = 6'b001001;
    localparam logic [5:0] OP_SLTI    = 6'b001010;
    localparam logic [5:0] OP_LW      = 6'b100011;
    localparam logic [5:0] OP_SW      = 6'b101011;

    // REGIMM rt selectors
    localparam logic [4:0] RT_BLTZ = 5'd0;
    localparam logic [4:0] RT_BGEZ = 5'd1;

    // SPECIAL funct codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_BREAK = 6'h0D;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    typedef enum logic [4:0] {
        KIND_UNKNOWN = 5'd0,
        KIND_ADDI    = 5'd1,
        KIND_ADDIU   = 5'd2,
        KIND_SW      = 5'd3,
        KIND_LW      = 5'd4,
        KIND_J       = 5'd5,
        KIND_BEQ     = 5'd6,
        KIND_BNE     = 5'd7,
        KIND_BGEZ    = 5'd8,
        KIND_BGTZ    = 5'd9,
        KIND_BLEZ    = 5'd10,
        KIND_BLTZ    = 5'd11,
        KIND_BREAK   = 5'd12,
        KIND_SLT     = 5'd13,
        KIND_SLTI    = 5'd14,
        KIND_SLTU    = 5'd15,
        KIND_SLL     = 5'd16,
        KIND_SRL     = 5'd17,
        KIND_SRA     = 5'd18,
        KIND_SUB     = 5'd19,
        KIND_SUBU    = 5'd20,
        KIND_ADD     = 5'd21,
        KIND_ADDU    = 5'd22,
        KIND_AND     = 5'd23,
        KIND_OR      = 5'd24,
        KIND_XOR     = 5'd25,
        KIND_NOR     = 5'd26,
        KIND_NOP     = 5'd27,
        KIND_DATA    = 5'd28,
        KIND_EMPTY   = 5'd29
    } kind_t;

endpackage

@@ hw/rtl/mips_subset_instruction_decoder_top.sv @@
// ----------------------------------------------------------------------------
// MIPS subset instruction decoder
// Classifies one instruction word per item and extracts its fields.
// ----------------------------------------------------------------------------
// Channel    Dir  Width  Contents
// s_axis     in   64     instr_word, word_address
// m_axis     out  96     kind, rs, rt, rd, shift, value, jump target
// cfg        in   32     data_start_address
//
// Two register stages: input register, then decode into the result register.
// An accepted item passes the input register, then the result register; one item per cycle unless m_axis stalls.
// Either stage holds its item while the one after it is full and stalled.
// Reset clears stage valids and the break flag and sets data_start_address to 700.
// ----------------------------------------------------------------------------
`include "mips_subset_instruction_decoder_top_defines.svh"

module mips_subset_instruction_decoder_top
    import msid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] instr_word, [63:32] word_address

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] kind, [9:5] rs_field, [14:10] rt_field, [19:15] rd_field,
    // [24:20] shift_amount, [56:25] signed_value, [88:57] jump_target, rest zero
    output logic [95:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data        // data_start_address
);

    logic [31:0] data_start_reg;

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic [31:0] in_addr_reg;

    logic        after_break_reg;
    logic        after_break_next;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [4:0]         out_rs_reg;
    logic [4:0]         out_rt_reg;
    logic [4:0]         out_rd_reg;
    logic [4:0]         out_sa_reg;
    logic signed [31:0] out_value_reg;
    logic [31:0]        out_jump_reg;

    kind_t              dec_kind;
    logic [4:0]         dec_rs;
    logic [4:0]         dec_rt;
    logic [4:0]         dec_rd;
    logic [4:0]         dec_sa;
    logic signed [31:0] dec_value;
    logic [31:0]        dec_jump;

    logic in_load;
    logic out_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= DATA_START_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            data_start_reg <= cfg_data;
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_word_reg <= s_axis_tdata[31:0];
            in_addr_reg <= s_axis_tdata[63:32];
        end
    end

    // Decode
    always_comb
    begin
        logic [5:0] op;
        logic [5:0] funct;
        logic       rd_nz;

        op    = in_word_reg[31:26];
        funct = in_word_reg[5:0];
        dec_rs = in_word_reg[25:21];
        dec_rt = in_word_reg[20:16];
        dec_rd = in_word_reg[15:11];
        dec_sa = in_word_reg[10:6];
        rd_nz  = (dec_rd != 5'd0);
        dec_kind  = KIND_UNKNOWN;
        dec_value = '0;
        dec_jump  = '0;

        if (after_break_reg)
        begin
            dec_rs = '0;
            dec_rt = '0;
            dec_rd = '0;
            dec_sa = '0;
            if (in_addr_reg > data_start_reg)
            begin
                dec_kind  = KIND_DATA;
                dec_value = in_word_reg;
            end
            else
            begin
                dec_kind = KIND_EMPTY;
            end
        end
        else
        begin
            case (op)
                OP_ADDI:  dec_kind = KIND_ADDI;
                OP_ADDIU: dec_kind = KIND_ADDIU;
                OP_SW:    dec_kind = KIND_SW;
                OP_LW:    dec_kind = KIND_LW;
                OP_SLTI:  dec_kind = KIND_SLTI;
                OP_J:     dec_kind = KIND_J;
                OP_BEQ:   dec_kind = KIND_BEQ;
                OP_BNE:   dec_kind = KIND_BNE;
                OP_BGTZ:  dec_kind = KIND_BGTZ;
                OP_BLEZ:  dec_kind = KIND_BLEZ;
                OP_REGIMM:
                begin
                    if (dec_rt == RT_BGEZ)
                        dec_kind = KIND_BGEZ;
                    else if (dec_rt == RT_BLTZ)
                        dec_kind = KIND_BLTZ;
                end
                OP_SPECIAL:
                begin
                    case (funct)
                        FN_BREAK: dec_kind = KIND_BREAK;
                        FN_SLT:   dec_kind = KIND_SLT;
                        FN_SLTU:  dec_kind = KIND_SLTU;
                        // all-zero shift word (rs ignored) is a NOP
                        FN_SLL:   dec_kind = ((dec_rd | dec_sa | dec_rt) != 5'd0) ?
                                             KIND_SLL : KIND_NOP;
                        FN_SRL:   dec_kind = rd_nz ? KIND_SRL  : KIND_UNKNOWN;
                        FN_SRA:   dec_kind = rd_nz ? KIND_SRA  : KIND_UNKNOWN;
                        FN_SUB:   dec_kind = rd_nz ? KIND_SUB  : KIND_UNKNOWN;
                        FN_SUBU:  dec_kind = rd_nz ? KIND_SUBU : KIND_UNKNOWN;
                        FN_ADD:   dec_kind = rd_nz ? KIND_ADD  : KIND_UNKNOWN;
                        FN_ADDU:  dec_kind = rd_nz ? KIND_ADDU : KIND_UNKNOWN;
                        FN_AND:   dec_kind = rd_nz ? KIND_AND  : KIND_UNKNOWN;
                        FN_OR:    dec_kind = rd_nz ? KIND_OR   : KIND_UNKNOWN;
                        FN_XOR:   dec_kind = rd_nz ? KIND_XOR  : KIND_UNKNOWN;
                        FN_NOR:   dec_kind = rd_nz ? KIND_NOR  : KIND_UNKNOWN;
                        default:  dec_kind = KIND_UNKNOWN;
                    endcase
                end
                default: dec_kind = KIND_UNKNOWN;
            endcase

            if (dec_kind inside {KIND_ADDI, KIND_ADDIU, KIND_SW, KIND_LW, KIND_SLTI})
            begin
                dec_value = {{16{in_word_reg[15]}}, in_word_reg[15:0]};
            end
            else if (dec_kind inside {KIND_BEQ, KIND_BNE, KIND_BGEZ, KIND_BGTZ,
                                      KIND_BLEZ, KIND_BLTZ})
            begin
                dec_value = {{14{in_word_reg[15]}}, in_word_reg[15:0], 2'b00};
            end
            else if (dec_kind == KIND_J)
            begin
                // region bits come from the jump word's own address
                dec_jump = {in_addr_reg[31:28], in_word_reg[25:0], 2'b00};
            end
        end
    end

    assign after_break_next = after_break_reg || (out_load && (dec_kind == KIND_BREAK));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_break_reg <= 1'b0;
        end
        else
        begin
            after_break_reg <= after_break_next;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= dec_kind;
            out_rs_reg    <= dec_rs;
            out_rt_reg    <= dec_rt;
            out_rd_reg    <= dec_rd;
            out_sa_reg    <= dec_sa;
            out_value_reg <= dec_value;
            out_jump_reg  <= dec_jump;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_jump_reg, out_value_reg, out_sa_reg, out_rd_reg,
                            out_rt_reg, out_rs_reg, out_kind_reg};

    `MSID_ASSERT_NEXT(a_break_sticky, after_break_reg, after_break_reg, "break flag cleared")
    `MSID_ASSERT_NEXT(a_after_break_kind, out_load && after_break_reg,
        out_kind_reg == KIND_DATA || out_kind_reg == KIND_EMPTY, "bad kind after break")
    `MSID_ASSERT_NOW(a_jump_only_j, out_valid_reg && out_kind_reg != KIND_J,
        out_jump_reg == 32'd0, "jump target on non-jump item")
    `MSID_ASSERT_NEXT(a_input_held, in_valid_reg && !out_load, in_valid_reg,
        "input stage item dropped")

endmodule

@@ verif/mips_subset_instruction_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// MIPS subset instruction decoder testbench
// Drives instruction words and addresses into the decoder and checks every
// decoded result against an in-bench predictor. It covers the opcode and
// funct classes, immediate and branch offset extension and the jump target.
// After a BREAK it checks DATA/EMPTY against several address thresholds.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module mips_subset_instruction_decoder_top_test;
    import msid_pkg::*;

    // Same layout as m_axis_tdata[88:0], kind in the low bits
    typedef struct packed {
        logic [31:0] jump_target;
        logic [31:0] value;
        logic [4:0]  shamt;
        logic [4:0]  rd;
        logic [4:0]  rt;
        logic [4:0]  rs;
        kind_t       kind;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] instr_word, [63:32] word_address
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;     // kind, rs, rt, rd, shift, value, jump target
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;         // data_start_address

    // Predictor state
    logic        break_seen;
    logic [31:0] data_start;
    decoded_t    pending_decodes[$];

    int mismatch_count;
    int src_stretch;
    bit src_calm;
    int sink_stretch;
    bit sink_calm;
    int sink_wait;

    mips_subset_instruction_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Wait draw in random stretches, each stretch either busy idling or none at all
    function automatic int draw_wait(inout int stretch_left, inout bit calm);
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(10, 60);
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic decoded_t predict_decode(input logic [31:0] word,
                                                input logic [31:0] addr);
        decoded_t    r;
        logic [31:0] imm;
        r = '0;
        imm = {{16{word[15]}}, word[15:0]};
        if (break_seen)
        begin
            if (addr > data_start)
            begin
                r.kind = KIND_DATA;
                r.value = word;
            end
            else
                r.kind = KIND_EMPTY;
        end
        else
        begin
            r.rs = word[25:21];
            r.rt = word[20:16];
            r.rd = word[15:11];
            r.shamt = word[10:6];
            r.kind = KIND_UNKNOWN;
            case (word[31:26])
                OP_ADDI:  r.kind = KIND_ADDI;
                OP_ADDIU: r.kind = KIND_ADDIU;
                OP_SW:    r.kind = KIND_SW;
                OP_LW:    r.kind = KIND_LW;
                OP_SLTI:  r.kind = KIND_SLTI;
                OP_J:     r.kind = KIND_J;
                OP_BEQ:   r.kind = KIND_BEQ;
                OP_BNE:   r.kind = KIND_BNE;
                OP_BGTZ:  r.kind = KIND_BGTZ;
                OP_BLEZ:  r.kind = KIND_BLEZ;
                OP_REGIMM:
                begin
                    if (r.rt == RT_BGEZ)
                        r.kind = KIND_BGEZ;
                    else if (r.rt == RT_BLTZ)
                        r.kind = KIND_BLTZ;
                end
                OP_SPECIAL:
                begin
                    // rd zero turns most register ops into unknown; SLT/SLTU don't care
                    case (word[5:0])
                        FN_BREAK: r.kind = KIND_BREAK;
                        FN_SLT:   r.kind = KIND_SLT;
                        FN_SLTU:  r.kind = KIND_SLTU;
                        FN_SLL:   r.kind = ((r.rt | r.rd | r.shamt) != 5'd0) ? KIND_SLL
                                                                           : KIND_NOP;
                        FN_SRL:   r.kind = (r.rd != 5'd0) ? KIND_SRL  : KIND_UNKNOWN;
                        FN_SRA:   r.kind = (r.rd != 5'd0) ? KIND_SRA  : KIND_UNKNOWN;
                        FN_SUB:   r.kind = (r.rd != 5'd0) ? KIND_SUB  : KIND_UNKNOWN;
                        FN_SUBU:  r.kind = (r.rd != 5'd0) ? KIND_SUBU : KIND_UNKNOWN;
                        FN_ADD:   r.kind = (r.rd != 5'd0) ? KIND_ADD  : KIND_UNKNOWN;
                        FN_ADDU:  r.kind = (r.rd != 5'd0) ? KIND_ADDU : KIND_UNKNOWN;
                        FN_AND:   r.kind = (r.rd != 5'd0) ? KIND_AND  : KIND_UNKNOWN;
                        FN_OR:    r.kind = (r.rd != 5'd0) ? KIND_OR   : KIND_UNKNOWN;
                        FN_XOR:   r.kind = (r.rd != 5'd0) ? KIND_XOR  : KIND_UNKNOWN;
                        FN_NOR:   r.kind = (r.rd != 5'd0) ? KIND_NOR  : KIND_UNKNOWN;
                        default:  r.kind = KIND_UNKNOWN;
                    endcase
                end
                default: r.kind = KIND_UNKNOWN;
            endcase
            case (r.kind)
                KIND_ADDI, KIND_ADDIU, KIND_SW, KIND_LW, KIND_SLTI:
                    r.value = imm;
                KIND_BEQ, KIND_BNE, KIND_BGEZ, KIND_BGTZ, KIND_BLEZ, KIND_BLTZ:
                    r.value = {imm[29:0], 2'b00};
                KIND_J:
                    r.jump_target = {addr[31:28], word[25:0], 2'b00};
                KIND_BREAK:
                    break_seen = 1'b1;
                default:
                    ;
            endcase
        end
        return r;
    endfunction

    // Random instruction, never a BREAK
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5:
                case ($urandom_range(0, 9))
                    0:       w[31:26] = OP_ADDI;
                    1:       w[31:26] = OP_ADDIU;
                    2:       w[31:26] = OP_SLTI;
                    3:       w[31:26] = OP_LW;
                    4:       w[31:26] = OP_SW;
                    5:       w[31:26] = OP_BEQ;
                    6:       w[31:26] = OP_BNE;
                    7:       w[31:26] = OP_BLEZ;
                    8:       w[31:26] = OP_BGTZ;
                    default: w[31:26] = OP_J;
                endcase
            6:
            begin
                w[31:26] = OP_REGIMM;
                w[20:16] = {4'd0, w[16]};
            end
            7, 8, 9, 10, 11:
            begin
                w[31:26] = OP_SPECIAL;
                case ($urandom_range(0, 12))
                    0:       w[5:0] = FN_SLT;
                    1:       w[5:0] = FN_SLTU;
                    2:       w[5:0] = FN_SLL;
                    3:       w[5:0] = FN_SRL;
                    4:       w[5:0] = FN_SRA;
                    5:       w[5:0] = FN_SUB;
                    6:       w[5:0] = FN_SUBU;
                    7:       w[5:0] = FN_ADD;
                    8:       w[5:0] = FN_ADDU;
                    9:       w[5:0] = FN_AND;
                    10:      w[5:0] = FN_OR;
                    11:      w[5:0] = FN_XOR;
                    default: w[5:0] = FN_NOR;
                endcase
                if ($urandom_range(0, 3) == 0)
                    w[15:11] = 5'd0;
            end
            12:
            begin
                // shift word near the SLL/NOP boundary
                w[31:26] = OP_SPECIAL;
                w[5:0] = FN_SLL;
                if ($urandom_range(0, 1) == 0)
                    w[20:16] = 5'd0;
                if ($urandom_range(0, 1) == 0)
                    w[15:11] = 5'd0;
                if ($urandom_range(0, 1) == 0)
                    w[10:6] = 5'd0;
            end
            13:
                w[31:26] = OP_REGIMM;
            14:
                w[31:26] = OP_SPECIAL;
            default:
                ;
        endcase
        if (w[31:26] == OP_SPECIAL && w[5:0] == FN_BREAK)
            w[5:0] = FN_SLT;
        return w;
    endfunction

    // Entered just after a rising edge; returns at the edge that took the item
    task automatic send_word(input logic [31:0] word, input logic [31:0] addr);
        int gap;
        gap = draw_wait(src_stretch, src_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {addr, word};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_decodes.push_back(predict_decode(word, addr));
    endtask

    task automatic drain();
        int guard;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_decodes.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_data_start(input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        data_start = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_decode();
        // immediates at their extremes
        send_word({OP_ADDI, 5'd31, 5'd0, 16'h7FFF}, 32'h0000_0000);
        send_word({OP_ADDIU, 5'd0, 5'd31, 16'h8000}, 32'hFFFF_FFFC);
        send_word({OP_SLTI, 5'd17, 5'd10, 16'hFFFF}, 32'h0000_0040);
        send_word({OP_LW, 5'd29, 5'd8, 16'h0000}, 32'h0000_0044);
        send_word({OP_SW, 5'd29, 5'd31, 16'h1234}, 32'h0000_0048);
        // jump base comes from this word's own address, not address plus four
        send_word({OP_J, 26'h3FF_FFFF}, 32'hEFFF_FFFC);
        send_word({OP_J, 26'h000_0000}, 32'h1000_0000);
        // branch offsets: most negative, most positive, minus one, zero
        send_word({OP_BEQ, 5'd1, 5'd2, 16'h8000}, 32'h0000_0100);
        send_word({OP_BNE, 5'd3, 5'd4, 16'h7FFF}, 32'h0000_0104);
        send_word({OP_BLEZ, 5'd5, 5'd0, 16'hFFFF}, 32'h0000_0108);
        send_word({OP_BGTZ, 5'd6, 5'd0, 16'h0000}, 32'h0000_010C);
        send_word({OP_REGIMM, 5'd7, RT_BGEZ, 16'hFFFE}, 32'h0000_0110);
        send_word({OP_REGIMM, 5'd8, RT_BLTZ, 16'h0001}, 32'h0000_0114);
        send_word({OP_REGIMM, 5'd9, 5'd2, 16'h0010}, 32'h0000_0118);
        // register ops; SLT with rd zero still decodes
        send_word({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_SLT}, 32'h0000_0200);
        send_word({OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, FN_SLTU}, 32'h0000_0204);
        send_word({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd31, FN_SLL}, 32'h0000_0208);
        send_word({OP_SPECIAL, 5'd0, 5'd3, 5'd4, 5'd5, FN_SRL}, 32'h0000_020C);
        send_word({OP_SPECIAL, 5'd0, 5'd6, 5'd7, 5'd1, FN_SRA}, 32'h0000_0210);
        send_word({OP_SPECIAL, 5'd8, 5'd9, 5'd10, 5'd0, FN_SUB}, 32'h0000_0214);
        send_word({OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd31, FN_SUBU}, 32'h0000_0218);
        send_word({OP_SPECIAL, 5'd11, 5'd12, 5'd13, 5'd0, FN_ADD}, 32'h0000_021C);
        send_word({OP_SPECIAL, 5'd14, 5'd15, 5'd16, 5'd0, FN_ADDU}, 32'h0000_0220);
        send_word({OP_SPECIAL, 5'd17, 5'd18, 5'd19, 5'd0, FN_AND}, 32'h0000_0224);
        send_word({OP_SPECIAL, 5'd20, 5'd21, 5'd22, 5'd0, FN_OR}, 32'h0000_0228);
        send_word({OP_SPECIAL, 5'd23, 5'd24, 5'd25, 5'd0, FN_XOR}, 32'h0000_022C);
        send_word({OP_SPECIAL, 5'd26, 5'd27, 5'd28, 5'd0, FN_NOR}, 32'h0000_0230);
        // add with rd zero -> unknown
        send_word({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_ADD}, 32'h0000_0234);
        // nop: all-zero word, and rs alone set
        send_word(32'h0000_0000, 32'h0000_0238);
        send_word({OP_SPECIAL, 5'd31, 5'd0, 5'd0, 5'd0, FN_SLL}, 32'h0000_023C);
        // unknown opcode and unknown funct
        send_word(32'hFFFF_FFFF, 32'h0000_0240);
        send_word({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd4, 6'h3F}, 32'h0000_0244);
        drain();
    endtask

    task automatic test_random_decode();
        repeat (1450)
            send_word(random_instruction(), $urandom());
        drain();
    endtask

    // Words after break, biased toward addresses around the threshold
    task automatic run_data_items(input int count);
        logic [31:0] word;
        logic [31:0] addr;
        repeat (count)
        begin
            word = $urandom();
            if ($urandom_range(0, 3) == 0)
            begin
                word[31:26] = OP_SPECIAL;
                word[5:0] = FN_BREAK;
            end
            case ($urandom_range(0, 7))
                0:       addr = data_start;
                1:       addr = data_start + 32'd1;
                2:       addr = data_start - 32'd1;
                3:       addr = 32'h0000_0000;
                4:       addr = 32'hFFFF_FFFF;
                default: addr = $urandom();
            endcase
            send_word(word, addr);
        end
        drain();
    endtask

    task automatic test_break_and_data();
        send_word({OP_SPECIAL, 20'hF_FFFF, FN_BREAK}, 32'h0000_0300);
        send_word(32'hFFFF_FFFF, data_start);
        send_word(32'h8000_0000, data_start + 32'd1);
        // another break word changes nothing
        send_word({OP_SPECIAL, 20'h0_0000, FN_BREAK}, 32'h0000_0000);
        send_word({OP_SPECIAL, 20'h0_0000, FN_BREAK}, 32'hFFFF_FFFF);
        run_data_items(75);
        write_data_start(32'h0000_0000);
        run_data_items(75);
        write_data_start(32'hFFFF_FFFF);
        run_data_items(75);
        write_data_start(32'h8000_0000);
        run_data_items(75);
        write_data_start($urandom_range(0, 4096));
        run_data_items(75);
        write_data_start($urandom());
        run_data_items(75);
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = decoded_t'(m_axis_tdata[88:0]);
            if (pending_decodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got.kind !== want.kind || got.rs !== want.rs || got.rt !== want.rt ||
                    got.rd !== want.rd || got.shamt !== want.shamt ||
                    got.value !== want.value || got.jump_target !== want.jump_target ||
                    m_axis_tdata[95:89] !== 7'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: want kind=%0d rs=%0d rt=%0d rd=%0d sa=%0d val=%h jt=%h",
                                 want.kind, want.rs, want.rt, want.rd, want.shamt,
                                 want.value, want.jump_target);
                        $display("          got  kind=%0d rs=%0d rt=%0d rd=%0d sa=%0d val=%h jt=%h pad=%h",
                                 got.kind, got.rs, got.rt, got.rd, got.shamt,
                                 got.value, got.jump_target, m_axis_tdata[95:89]);
                    end
                end
            end
            sink_wait = draw_wait(sink_stretch, sink_calm);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        break_seen = 1'b0;
        data_start = DATA_START_RESET;
        mismatch_count = 0;
        src_stretch = 0;
        src_calm = 1'b0;
        sink_stretch = 0;
        sink_calm = 1'b0;
        sink_wait = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_decode();
        test_random_decode();
        test_break_and_data();
        drain();
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/msid_pkg.sv
hw/rtl/mips_subset_instruction_decoder_top.sv
verif/mips_subset_instruction_decoder_top_test.sv
